// File: rtl/bvpd_pkg.sv
// Shared types, constants and helpers of the lattice deformation block.
package bvpd_pkg;
	localparam int CW = 20;
	localparam int VW = 60;
	localparam int WW = 31;
	localparam int PW = 64;
	localparam int AW = 9;
	localparam int SD = 512;
	localparam logic [WW-1:0] ONE_Q30 = 31'h4000_0000;

	typedef logic signed [CW-1:0] coord_t;
	typedef logic [VW-1:0] vec_t;
	typedef logic [WW-1:0] wgt_t;

	typedef enum logic [1:0] {
		KIND_SET  = 2'd0,
		KIND_ADD  = 2'd1,
		KIND_EVAL = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		REG_ORIGIN = 3'd0,
		REG_EDGE_S = 3'd1,
		REG_EDGE_T = 3'd2,
		REG_EDGE_U = 3'd3,
		REG_PTS_S  = 3'd4,
		REG_PTS_T  = 3'd5,
		REG_PTS_U  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic start;
		logic signed [PW-1:0] num;
		logic signed [PW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic done;
		logic ok;
		wgt_t loc;
	} div_res_t;

	function automatic coord_t lane(vec_t v, logic [1:0] k);
		coord_t r;
		case (k)
			2'd0: r = v[19:0];
			2'd1: r = v[39:20];
			default: r = v[59:40];
		endcase
		return r;
	endfunction

	function automatic coord_t sat_c(logic signed [61:0] v);
		coord_t r;
		if (v > 62'sd524287) r = 20'sh7FFFF;
		else if (v < -62'sd524288) r = 20'sh80000;
		else r = CW'(v);
		return r;
	endfunction
endpackage

// File: rtl/bvpd_ifs.sv
// Handshake channels: input items, result items and register writes.
interface bvpd_in_if;
	import bvpd_pkg::*;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [8:0] point_index;
	coord_t coord_x;
	coord_t coord_y;
	coord_t coord_z;
	modport source(output valid, kind, point_index, coord_x, coord_y, coord_z, input ready);
	modport sink(input valid, kind, point_index, coord_x, coord_y, coord_z, output ready);
endinterface

interface bvpd_out_if;
	import bvpd_pkg::*;
	logic valid;
	logic ready;
	coord_t out_x;
	coord_t out_y;
	coord_t out_z;
	logic inside_box;
	modport source(output valid, out_x, out_y, out_z, inside_box, input ready);
	modport sink(input valid, out_x, out_y, out_z, inside_box, output ready);
endinterface

interface bvpd_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [59:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: rtl/bezier_volume_point_deform.sv
// Trivariate Bernstein free-form deformation over a control point lattice.
// Set writes the lattice store on acceptance and add writes the saturated sum in S_ADD.
// Evaluate runs every product through one shared 42x32 multiplier: cross products,
// dot products and restoring divisions per axis, the Bernstein recursion steps, and
// the tensor sum over all control points (ns*nt*nu points). A point outside the box
// returns after its failing division. The input is not ready while an item is in work;
// a finished result waits in its output register.
module bezier_volume_point_deform #(
	parameter int MAX_POINTS_PER_AXIS = 8
) (
	input logic clk,
	input logic arst_n,
	bvpd_in_if.sink item,
	bvpd_cfg_if.sink cfg,
	bvpd_out_if.source result
);
	import bvpd_pkg::*;

	localparam int IW = $clog2(MAX_POINTS_PER_AXIS);
	localparam int NW = IW + 1;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_ADD   = 8'b0000_0010,
		S_CROSS = 8'b0000_0100,
		S_DOT   = 8'b0000_1000,
		S_DIV   = 8'b0001_0000,
		S_BERN  = 8'b0010_0000,
		S_SUM   = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	function automatic logic [NW-1:0] eff_pts(logic [3:0] r);
		logic [4:0] rv;
		rv = {1'b0, r};
		if (rv < 5'd2) return NW'(2);
		if (rv > 5'(MAX_POINTS_PER_AXIS)) return NW'(MAX_POINTS_PER_AXIS);
		return NW'(rv);
	endfunction

	state_t state_q;
	vec_t org_q, es_q, et_q, eu_q;
	logic [3:0] ps_q, pt_q, pu_q;
	coord_t p_q [3];
	logic signed [20:0] dx_q [3];
	logic [AW-1:0] idx_q;
	logic signed [40:0] perp_q [3][3];
	logic signed [63:0] acc_q;
	logic signed [63:0] num_q;
	logic signed [73:0] prod_s1;
	wgt_t loc_q [3];
	wgt_t ws_q [MAX_POINTS_PER_AXIS];
	wgt_t wt_q [MAX_POINTS_PER_AXIS];
	wgt_t wu_q [MAX_POINTS_PER_AXIS];
	wgt_t c_q;
	logic signed [61:0] res_q [3];
	vec_t mem [SD];
	vec_t rd_q;
	logic [1:0] ax_q, cp_q;
	logic tm_q, ph_q;
	logic [2:0] op_q;
	logic [IW-1:0] i_q, j_q, k_q;
	logic [AW-1:0] addr_q;
	logic div_run_q;
	logic inside_q;
	logic out_vld_q;
	coord_t ox_q, oy_q, oz_q;
	logic oin_q;

	logic acc_in;
	logic [NW-1:0] ns, nt, nu, nsel;
	logic [IW-1:0] k_last;
	vec_t ea, eb, ed;
	logic [1:0] d1, d2, dsel;
	logic [IW-1:0] widx, rs, rt, ru;
	wgt_t wr_s, wr_t, wr_u, wcur, scur, om;
	logic signed [41:0] ma;
	logic signed [31:0] mb;
	logic signed [63:0] prod64, bsum, dsum;
	wgt_t wnew, cnew;
	logic bern_wr, bern_ax_end, sum_pt_end, out_load, div_fin;
	div_req_t div_req;
	div_res_t div_res;
	logic mem_we;
	logic [AW-1:0] mem_wa, mem_ra;
	vec_t mem_wd;

	assign acc_in = item.valid && item.ready;
	assign item.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;

	always_comb begin
		ns = eff_pts(ps_q);
		nt = eff_pts(pt_q);
		nu = eff_pts(pu_q);
		nsel = (ax_q == 2'd0) ? ns : ((ax_q == 2'd1) ? nt : nu);
		k_last = IW'(nsel - NW'(1));
		ea = (ax_q == 2'd0) ? et_q : es_q;
		eb = (ax_q == 2'd2) ? et_q : eu_q;
		ed = (ax_q == 2'd0) ? es_q : ((ax_q == 2'd1) ? et_q : eu_q);
		d1 = (cp_q == 2'd2) ? 2'd0 : cp_q + 2'd1;
		d2 = (cp_q == 2'd0) ? 2'd2 : cp_q - 2'd1;
		dsel = 2'(op_q - 3'd2);
		widx = tm_q ? i_q - IW'(1) : i_q;
		rs = (state_q == S_BERN) ? widx : i_q;
		rt = (state_q == S_BERN) ? widx : j_q;
		ru = (state_q == S_BERN) ? widx : k_q;
		wr_s = ws_q[rs];
		wr_t = wt_q[rt];
		wr_u = wu_q[ru];
		wcur = (ax_q == 2'd0) ? wr_s : ((ax_q == 2'd1) ? wr_t : wr_u);
		scur = loc_q[ax_q];
		om = ONE_Q30 - scur;
		case (state_q)
			S_CROSS: begin
				ma = 42'(lane(ea, tm_q ? d2 : d1));
				mb = 32'(lane(eb, tm_q ? d1 : d2));
			end
			S_DOT: begin
				ma = 42'(perp_q[ax_q][cp_q]);
				mb = tm_q ? 32'(lane(ed, cp_q)) : 32'(dx_q[cp_q]);
			end
			S_BERN: begin
				ma = {11'b0, (tm_q ? scur : om)};
				mb = {1'b0, wcur};
			end
			S_SUM: begin
				if (op_q == 3'd0) begin
					ma = {11'b0, wr_s};
					mb = {1'b0, wr_t};
				end else if (op_q == 3'd1) begin
					ma = {11'b0, c_q};
					mb = {1'b0, wr_u};
				end else begin
					ma = {11'b0, c_q};
					mb = 32'(lane(rd_q, dsel));
				end
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
		prod64 = prod_s1[63:0];
		bsum = tm_q ? acc_q + prod64 : prod64;
		wnew = WW'((bsum + 64'sd536870912) >>> 30);
		cnew = WW'((prod64 + 64'sd536870912) >>> 30);
		dsum = (cp_q == 2'd0) ? prod64 : acc_q + prod64;
		bern_wr = (state_q == S_BERN) && ph_q && (tm_q || i_q == '0);
		bern_ax_end = bern_wr && i_q == '0 && k_q == k_last;
		sum_pt_end = (state_q == S_SUM) && ph_q && op_q == 3'd4;
		out_load = (state_q == S_DONE) && (!out_vld_q || result.ready);
		div_fin = (state_q == S_DIV) && div_run_q && div_res.done;
		div_req.start = (state_q == S_DIV) && !div_run_q;
		div_req.num = num_q;
		div_req.den = acc_q;
		mem_we = (acc_in && item.kind == KIND_SET) || (state_q == S_ADD);
		mem_wa = (state_q == S_ADD) ? idx_q : item.point_index;
		if (state_q == S_ADD)
			mem_wd = {sat_c(62'(lane(rd_q, 2'd2)) + 62'(p_q[2])),
				sat_c(62'(lane(rd_q, 2'd1)) + 62'(p_q[1])),
				sat_c(62'(lane(rd_q, 2'd0)) + 62'(p_q[0]))};
		else
			mem_wd = {item.coord_z, item.coord_y, item.coord_x};
		mem_ra = (state_q == S_SUM) ? addr_q : item.point_index;
	end

	bvpd_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.res(div_res)
	);

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		rd_q <= mem[mem_ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_q <= '0;
			es_q <= '0;
			et_q <= '0;
			eu_q <= '0;
			ps_q <= 4'd2;
			pt_q <= 4'd2;
			pu_q <= 4'd2;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_ORIGIN: org_q <= cfg.data;
				REG_EDGE_S: es_q <= cfg.data;
				REG_EDGE_T: et_q <= cfg.data;
				REG_EDGE_U: eu_q <= cfg.data;
				REG_PTS_S: ps_q <= cfg.data[3:0];
				REG_PTS_T: pt_q <= cfg.data[3:0];
				REG_PTS_U: pu_q <= cfg.data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ax_q <= '0;
			cp_q <= '0;
			tm_q <= 1'b0;
			ph_q <= 1'b0;
			op_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			addr_q <= '0;
			div_run_q <= 1'b0;
			inside_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (out_load)
				out_vld_q <= 1'b1;
			else if (result.ready)
				out_vld_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (acc_in) begin
						case (item.kind)
							KIND_ADD: state_q <= S_ADD;
							KIND_EVAL: begin
								state_q <= S_CROSS;
								ax_q <= '0;
								cp_q <= '0;
								tm_q <= 1'b0;
								ph_q <= 1'b0;
							end
							default: ;
						endcase
					end
				end
				S_ADD: state_q <= S_IDLE;
				S_CROSS: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						tm_q <= ~tm_q;
						if (tm_q) begin
							if (cp_q == 2'd2) begin
								cp_q <= '0;
								if (ax_q == 2'd2) begin
									ax_q <= '0;
									state_q <= S_DOT;
								end else
									ax_q <= ax_q + 2'd1;
							end else
								cp_q <= cp_q + 2'd1;
						end
					end
				end
				S_DOT: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (cp_q == 2'd2) begin
							cp_q <= '0;
							if (tm_q) begin
								tm_q <= 1'b0;
								state_q <= S_DIV;
							end else
								tm_q <= 1'b1;
						end else
							cp_q <= cp_q + 2'd1;
					end
				end
				S_DIV: begin
					if (!div_run_q)
						div_run_q <= 1'b1;
					else if (div_res.done) begin
						div_run_q <= 1'b0;
						if (!div_res.ok) begin
							inside_q <= 1'b0;
							state_q <= S_DONE;
						end else if (ax_q == 2'd2) begin
							ax_q <= '0;
							k_q <= IW'(1);
							i_q <= IW'(1);
							tm_q <= 1'b0;
							ph_q <= 1'b0;
							state_q <= S_BERN;
						end else begin
							ax_q <= ax_q + 2'd1;
							state_q <= S_DOT;
						end
					end
				end
				S_BERN: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (!tm_q && i_q != '0)
							tm_q <= 1'b1;
						else begin
							tm_q <= 1'b0;
							if (i_q == '0) begin
								if (k_q == k_last) begin
									if (ax_q == 2'd2) begin
										state_q <= S_SUM;
										i_q <= '0;
										j_q <= '0;
										k_q <= '0;
										op_q <= '0;
										addr_q <= '0;
									end else begin
										ax_q <= ax_q + 2'd1;
										k_q <= IW'(1);
										i_q <= IW'(1);
									end
								end else begin
									k_q <= k_q + IW'(1);
									i_q <= k_q + IW'(1);
								end
							end else
								i_q <= i_q - IW'(1);
						end
					end
				end
				S_SUM: begin
					ph_q <= ~ph_q;
					if (ph_q) begin
						if (op_q == 3'd4) begin
							op_q <= '0;
							addr_q <= addr_q + AW'(1);
							if (i_q == IW'(ns - NW'(1))) begin
								i_q <= '0;
								if (j_q == IW'(nt - NW'(1))) begin
									j_q <= '0;
									if (k_q == IW'(nu - NW'(1))) begin
										inside_q <= 1'b1;
										state_q <= S_DONE;
									end else
										k_q <= k_q + IW'(1);
								end else
									j_q <= j_q + IW'(1);
							end else
								i_q <= i_q + IW'(1);
						end else
							op_q <= op_q + 3'd1;
					end
				end
				S_DONE: begin
					if (out_load)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= ma * mb;
		if (acc_in) begin
			p_q[0] <= item.coord_x;
			p_q[1] <= item.coord_y;
			p_q[2] <= item.coord_z;
			dx_q[0] <= 21'(item.coord_x) - 21'(lane(org_q, 2'd0));
			dx_q[1] <= 21'(item.coord_y) - 21'(lane(org_q, 2'd1));
			dx_q[2] <= 21'(item.coord_z) - 21'(lane(org_q, 2'd2));
			idx_q <= item.point_index;
		end
		if (state_q == S_CROSS && ph_q) begin
			if (!tm_q)
				acc_q <= prod64;
			else
				perp_q[ax_q][cp_q] <= 41'(acc_q - prod64);
		end
		if (state_q == S_DOT && ph_q) begin
			acc_q <= dsum;
			if (cp_q == 2'd2 && !tm_q)
				num_q <= dsum;
		end
		if (div_fin && div_res.ok) begin
			loc_q[ax_q] <= div_res.loc;
			if (ax_q == 2'd2) begin
				for (int n = 0; n < MAX_POINTS_PER_AXIS; n++) begin
					ws_q[n] <= (n == 0) ? ONE_Q30 : '0;
					wt_q[n] <= (n == 0) ? ONE_Q30 : '0;
					wu_q[n] <= (n == 0) ? ONE_Q30 : '0;
				end
			end
		end
		if (state_q == S_BERN && ph_q) begin
			if (bern_wr) begin
				case (ax_q)
					2'd0: ws_q[i_q] <= wnew;
					2'd1: wt_q[i_q] <= wnew;
					default: wu_q[i_q] <= wnew;
				endcase
			end else
				acc_q <= prod64;
		end
		if (bern_ax_end && ax_q == 2'd2) begin
			res_q[0] <= '0;
			res_q[1] <= '0;
			res_q[2] <= '0;
		end
		if (state_q == S_SUM && ph_q) begin
			if (op_q == 3'd0 || op_q == 3'd1)
				c_q <= cnew;
			else
				res_q[dsel] <= res_q[dsel] + 62'(prod_s1);
		end
		if (out_load) begin
			oin_q <= inside_q;
			if (inside_q) begin
				ox_q <= sat_c((res_q[0] + 62'sd536870912) >>> 30);
				oy_q <= sat_c((res_q[1] + 62'sd536870912) >>> 30);
				oz_q <= sat_c((res_q[2] + 62'sd536870912) >>> 30);
			end else begin
				ox_q <= p_q[0];
				oy_q <= p_q[1];
				oz_q <= p_q[2];
			end
		end
	end

	assign result.valid = out_vld_q;
	assign result.out_x = ox_q;
	assign result.out_y = oy_q;
	assign result.out_z = oz_q;
	assign result.inside_box = oin_q;

`ifndef SYNTH
	a_done_load: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_vld_q && state_q == S_IDLE))
		else $error("result not loaded on leaving DONE");
	a_div_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> state_q == S_DIV)
		else $error("divider finished outside DIV");
	a_pass_through: assert property (@(posedge clk) disable iff (!arst_n)
		($rose(out_vld_q) && !oin_q) |-> (ox_q == p_q[0] && oz_q == p_q[2]))
		else $error("outside point not passed through");
	a_sum_order: assert property (@(posedge clk) disable iff (!arst_n)
		(sum_pt_end && state_q == S_SUM) |=> (op_q == 3'd0))
		else $error("tensor sum op counter out of step");
`endif
endmodule

// File: rtl/bvpd_div.sv
// Restoring divider for one local coordinate, one quotient bit per cycle.
module bvpd_div (
	input logic clk,
	input logic arst_n,
	input bvpd_pkg::div_req_t req,
	output bvpd_pkg::div_res_t res
);
	import bvpd_pkg::*;

	logic busy_q;
	logic done_q;
	logic ok_q;
	logic [4:0] itr_q;
	logic [PW-1:0] rem_q;
	logic [PW-1:0] dvs_q;
	logic [WW-1:0] quo_q;
	wgt_t loc_q;
	logic signed [PW-1:0] nn;
	logic signed [PW-1:0] dn;
	logic [PW:0] r2;
	logic ge;
	logic [WW-1:0] qn;

	always_comb begin
		dn = req.den[PW-1] ? -req.den : req.den;
		nn = req.den[PW-1] ? -req.num : req.num;
		r2 = {rem_q, 1'b0};
		ge = r2 >= {1'b0, dvs_q};
		qn = {quo_q[WW-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			ok_q <= 1'b0;
			itr_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.den == '0 || nn < 0 || nn > dn) begin
					done_q <= 1'b1;
					ok_q <= 1'b0;
				end else if (nn == dn) begin
					done_q <= 1'b1;
					ok_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					itr_q <= '0;
				end
			end else if (busy_q) begin
				itr_q <= itr_q + 5'd1;
				if (itr_q == 5'(WW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
					ok_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= nn;
			dvs_q <= dn;
			quo_q <= '0;
			loc_q <= ONE_Q30;
		end else if (busy_q) begin
			rem_q <= ge ? PW'(r2 - {1'b0, dvs_q}) : r2[PW-1:0];
			quo_q <= qn;
			if (itr_q == 5'(WW - 1))
				loc_q <= WW'(({1'b0, qn} + 32'd1) >> 1);
		end
	end

	assign res.done = done_q;
	assign res.ok = ok_q;
	assign res.loc = loc_q;
endmodule

// File: tb/sv/bvpd_checker.sv
// Checker: watches the channels, predicts each deformation result and compares it.
`timescale 1ns / 1ps
module bvpd_checker #(
	parameter int MAX_POINTS_PER_AXIS = 8
) (
	input logic clk,
	input logic arst_n,
	bvpd_in_if item,
	bvpd_out_if result,
	bvpd_cfg_if cfg,
	output int fails,
	output int pending,
	output int checked,
	output int deformed
);
	import bvpd_pkg::*;

	localparam longint unsigned Q30_ONE = 64'd1 << 30;
	localparam longint unsigned Q30_HALF = 64'd1 << 29;

	typedef struct {
		coord_t x;
		coord_t y;
		coord_t z;
		logic in_box;
	} point_res_t;

	vec_t lattice[SD];
	vec_t org, es, et, eu;
	logic [3:0] nps, npt, npu;
	point_res_t expected_points[$];

	function automatic longint comp(vec_t v, int k);
		coord_t c;
		c = v[20*k +: 20];
		return longint'(c);
	endfunction

	function automatic longint clamp20(longint v);
		if (v > 524287) return 524287;
		if (v < -524288) return -524288;
		return v;
	endfunction

	function automatic int clamp_pts(logic [3:0] r);
		if (r < 2) return 2;
		if (r > MAX_POINTS_PER_AXIS) return MAX_POINTS_PER_AXIS;
		return int'(r);
	endfunction

	function automatic vec_t pack3(longint a, longint b, longint c);
		return {c[19:0], b[19:0], a[19:0]};
	endfunction

	// local coordinate num/den into Q1.30, 0 when outside or degenerate
	function automatic bit to_local(longint num, longint den, output longint unsigned s);
		longint unsigned n, d, r, q;
		s = 0;
		if (den == 0) return 0;
		if (den < 0) begin
			den = -den;
			num = -num;
		end
		if (num < 0 || num > den) return 0;
		n = num;
		d = den;
		if (n == d) begin
			s = Q30_ONE;
			return 1;
		end
		r = n;
		q = 0;
		for (int k = 0; k < 31; k++) begin
			r = r << 1;
			q = q << 1;
			if (r >= d) begin
				r = r - d;
				q = q | 1;
			end
		end
		s = (q + 1) >> 1;
		return 1;
	endfunction

	function automatic void bern(input longint unsigned s, input int n,
			output longint unsigned w[MAX_POINTS_PER_AXIS]);
		longint unsigned om, acc;
		om = Q30_ONE - s;
		for (int i = 0; i < MAX_POINTS_PER_AXIS; i++) w[i] = 0;
		w[0] = Q30_ONE;
		for (int k = 1; k < n; k++) begin
			w[k] = 0;
			for (int i = k; i >= 0; i--) begin
				acc = om * w[i] + (i > 0 ? s * w[i-1] : 0);
				w[i] = (acc + Q30_HALF) >> 30;
			end
		end
	endfunction

	function automatic longint round30(longint acc);
		longint v;
		longint unsigned m;
		v = acc + longint'(Q30_HALF);
		if (v >= 0) return v >>> 30;
		m = -v;
		return -longint'((m + Q30_ONE - 1) >> 30);
	endfunction

	function automatic point_res_t deform(coord_t px, coord_t py, coord_t pz);
		longint p[3], e[3][3], pp[3][3], dx[3], acc[3], num, den;
		longint unsigned loc[3], c;
		longint unsigned ws[MAX_POINTS_PER_AXIS], wt[MAX_POINTS_PER_AXIS];
		longint unsigned wu[MAX_POINTS_PER_AXIS];
		int ns, nt, nu, a1, b1, fa, fb, ix;
		bit ok;
		vec_t ent;
		point_res_t r;
		p[0] = longint'(px);
		p[1] = longint'(py);
		p[2] = longint'(pz);
		for (int d = 0; d < 3; d++) begin
			e[0][d] = comp(es, d);
			e[1][d] = comp(et, d);
			e[2][d] = comp(eu, d);
			dx[d] = p[d] - comp(org, d);
		end
		for (int ax = 0; ax < 3; ax++) begin
			fa = (ax == 0) ? 1 : 0;
			fb = (ax == 2) ? 1 : 2;
			for (int d = 0; d < 3; d++) begin
				a1 = (d + 1) % 3;
				b1 = (d + 2) % 3;
				pp[ax][d] = e[fa][a1] * e[fb][b1] - e[fa][b1] * e[fb][a1];
			end
		end
		ok = 1;
		for (int ax = 0; ax < 3; ax++) begin
			if (ok) begin
				num = 0;
				den = 0;
				for (int d = 0; d < 3; d++) begin
					num += dx[d] * pp[ax][d];
					den += e[ax][d] * pp[ax][d];
				end
				ok = to_local(num, den, loc[ax]);
			end
		end
		if (!ok) begin
			r.x = px;
			r.y = py;
			r.z = pz;
			r.in_box = 1'b0;
			return r;
		end
		ns = clamp_pts(nps);
		nt = clamp_pts(npt);
		nu = clamp_pts(npu);
		bern(loc[0], ns, ws);
		bern(loc[1], nt, wt);
		bern(loc[2], nu, wu);
		for (int d = 0; d < 3; d++) acc[d] = 0;
		for (int k = 0; k < nu; k++)
			for (int j = 0; j < nt; j++)
				for (int i = 0; i < ns; i++) begin
					c = (ws[i] * wt[j] + Q30_HALF) >> 30;
					c = (c * wu[k] + Q30_HALF) >> 30;
					ix = (i + j * ns + k * ns * nt) % SD;
					ent = lattice[ix];
					for (int d = 0; d < 3; d++) acc[d] += longint'(c) * comp(ent, d);
				end
		r.x = coord_t'(clamp20(round30(acc[0])));
		r.y = coord_t'(clamp20(round30(acc[1])));
		r.z = coord_t'(clamp20(round30(acc[2])));
		r.in_box = 1'b1;
		return r;
	endfunction

	initial begin
		fails = 0;
		pending = 0;
		checked = 0;
		deformed = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		point_res_t want;
		vec_t cur;
		if (!arst_n) begin
			org = 0;
			es = 0;
			et = 0;
			eu = 0;
			nps = 2;
			npt = 2;
			npu = 2;
			expected_points.delete();
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					REG_ORIGIN: org = cfg.data;
					REG_EDGE_S: es = cfg.data;
					REG_EDGE_T: et = cfg.data;
					REG_EDGE_U: eu = cfg.data;
					REG_PTS_S: nps = cfg.data[3:0];
					REG_PTS_T: npt = cfg.data[3:0];
					REG_PTS_U: npu = cfg.data[3:0];
					default: ;
				endcase
			end
			if (result.valid && result.ready) begin
				if (expected_points.size() == 0) begin
					$error("result item with nothing expected");
					fails++;
				end else begin
					want = expected_points.pop_front();
					checked++;
					if (want.in_box) deformed++;
					if (result.out_x !== want.x) begin
						$error("out_x expected %0d got %0d", want.x, result.out_x);
						fails++;
					end
					if (result.out_y !== want.y) begin
						$error("out_y expected %0d got %0d", want.y, result.out_y);
						fails++;
					end
					if (result.out_z !== want.z) begin
						$error("out_z expected %0d got %0d", want.z, result.out_z);
						fails++;
					end
					if (result.inside_box !== want.in_box) begin
						$error("inside_box expected %0d got %0d", want.in_box,
							result.inside_box);
						fails++;
					end
				end
			end
			if (item.valid && item.ready) begin
				cur = lattice[item.point_index];
				case (item.kind)
					KIND_SET: lattice[item.point_index] = pack3(longint'(item.coord_x),
						longint'(item.coord_y), longint'(item.coord_z));
					KIND_ADD: lattice[item.point_index] = pack3(
						clamp20(comp(cur, 0) + longint'(item.coord_x)),
						clamp20(comp(cur, 1) + longint'(item.coord_y)),
						clamp20(comp(cur, 2) + longint'(item.coord_z)));
					KIND_EVAL: expected_points = {expected_points,
						deform(item.coord_x, item.coord_y, item.coord_z)};
					default: ;
				endcase
			end
		end
		pending = expected_points.size();
	end
endmodule

// File: tb/sv/bezier_volume_point_deform_tb.sv
// Testbench top: drives lattice, register and point items and gives the verdict.
`timescale 1ns / 1ps
module bezier_volume_point_deform_tb;
	import bvpd_pkg::*;

	localparam logic [1:0] KIND_NOP = 2'd3;
	localparam int IDLE_LIMIT = 40000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit item_hot = 0;
	bit no_idle = 0;
	vec_t org, es, et, eu;
	int sent = 0;
	int idle_cycles = 0;
	int fails, pending, checked, deformed;

	bvpd_in_if item();
	bvpd_out_if result();
	bvpd_cfg_if cfg();

	always #1 clk = ~clk;

	bezier_volume_point_deform uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.cfg(cfg),
		.result(result)
	);

	bvpd_checker chk (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.result(result),
		.cfg(cfg),
		.fails(fails),
		.pending(pending),
		.checked(checked),
		.deformed(deformed)
	);

	initial begin
		item.valid = 0;
		item.kind = 0;
		item.point_index = 0;
		item.coord_x = 0;
		item.coord_y = 0;
		item.coord_z = 0;
		cfg.valid = 0;
		cfg.index = 0;
		cfg.data = 0;
		result.ready = 0;
	end

	always @(posedge clk) begin
		if ((item.valid && item.ready) || (cfg.valid && cfg.ready) ||
				(result.valid && result.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAIL bezier_volume_point_deform");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// result side stalls
	initial begin
		int n;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			n = no_idle ? 0 : $urandom_range(0, 9);
			if (n > 0) begin
				result.ready <= 1'b0;
				repeat (n) @(posedge clk);
				result.ready <= 1'b1;
			end else if (!result.ready) begin
				result.ready <= 1'b1;
			end
			do @(posedge clk); while (!(result.valid && result.ready));
		end
	end

	function automatic coord_t srand(int span);
		return coord_t'(int'($urandom_range(0, 2 * span)) - span);
	endfunction

	function automatic coord_t anyc();
		return coord_t'($urandom());
	endfunction

	function automatic vec_t pack(coord_t x, coord_t y, coord_t z);
		return {z, y, x};
	endfunction

	function automatic coord_t along(int d, int a, int b, int c);
		longint v;
		v = longint'(lane(org, 2'(d))) + ((longint'(a) * lane(es, 2'(d)) +
			longint'(b) * lane(et, 2'(d)) + longint'(c) * lane(eu, 2'(d))) >>> 16);
		return v[19:0];
	endfunction

	task automatic send(logic [1:0] k, logic [8:0] idx, coord_t x, coord_t y, coord_t z);
		int g;
		if (!item_hot) item.valid <= 1'b1;
		item.kind <= k;
		item.point_index <= idx;
		item.coord_x <= x;
		item.coord_y <= y;
		item.coord_z <= z;
		do @(posedge clk); while (!item.ready);
		sent++;
		g = no_idle ? 0 : $urandom_range(0, 9);
		item_hot = (g == 0);
		if (g > 0) begin
			item.valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic settle();
		if (item_hot) begin
			item.valid <= 1'b0;
			item_hot = 0;
		end
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t r, vec_t d);
		cfg.valid <= 1'b1;
		cfg.index <= r;
		cfg.data <= d;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(vec_t o, vec_t s, vec_t t, vec_t u, vec_t ps, vec_t pt, vec_t pu);
		settle();
		cfg_write(REG_ORIGIN, o);
		cfg_write(REG_EDGE_S, s);
		cfg_write(REG_EDGE_T, t);
		cfg_write(REG_EDGE_U, u);
		cfg_write(REG_PTS_S, ps);
		cfg_write(REG_PTS_T, pt);
		cfg_write(REG_PTS_U, pu);
		org = o;
		es = s;
		et = t;
		eu = u;
	endtask

	function automatic coord_t major();
		int m;
		m = $urandom_range(4096, 131072);
		return coord_t'($urandom_range(0, 1) ? -m : m);
	endfunction

	function automatic int clampn(int v);
		return v < 2 ? 2 : (v > 8 ? 8 : v);
	endfunction

	task automatic eval_in_box();
		int a, b, c;
		if ($urandom_range(0, 9) == 0) begin
			a = $urandom_range(0, 73728) - 4096;
			b = $urandom_range(0, 73728) - 4096;
			c = $urandom_range(0, 73728) - 4096;
		end else begin
			a = $urandom_range(0, 65536);
			b = $urandom_range(0, 65536);
			c = $urandom_range(0, 65536);
		end
		send(KIND_EVAL, 9'($urandom()), along(0, a, b, c), along(1, a, b, c), along(2, a, b, c));
	endtask

	task automatic random_item(inout int evals_left);
		int r;
		r = $urandom_range(0, 99);
		if (r < 55 && evals_left > 0) begin
			eval_in_box();
			evals_left--;
		end else if (r < 70) begin
			if ($urandom_range(0, 3) == 0)
				send(KIND_SET, 9'($urandom()), anyc(), anyc(), anyc());
			else
				send(KIND_SET, 9'($urandom()), srand(131072), srand(131072), srand(131072));
		end else if (r < 88) begin
			if ($urandom_range(0, 4) == 0)
				send(KIND_ADD, 9'($urandom()), anyc(), anyc(), anyc());
			else
				send(KIND_ADD, 9'($urandom()), srand(8192), srand(8192), srand(8192));
		end else if (r < 95) begin
			send(KIND_NOP, 9'($urandom()), anyc(), anyc(), anyc());
		end else if (evals_left > 0) begin
			send(KIND_EVAL, 9'($urandom()), anyc(), anyc(), anyc());
			evals_left--;
		end
	endtask

	initial begin
		int ps, pt, pu, vol, n_items, evals_left, settings;
		vec_t o, s, t, u;
		settings = 1;
		org = 0;
		es = 0;
		et = 0;
		eu = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// load the whole lattice store
		for (int i = 0; i < SD; i++) begin
			if ($urandom_range(0, 3) == 0)
				send(KIND_SET, 9'(i), anyc(), anyc(), anyc());
			else
				send(KIND_SET, 9'(i), srand(131072), srand(131072), srand(131072));
		end

		// degenerate box at reset, ignored kind
		send(KIND_EVAL, 9'h1FF, coord_t'(-524288), coord_t'(524287), 0);
		send(KIND_NOP, 9'h1FF, coord_t'(-1), coord_t'(-1), coord_t'(-1));

		configure(pack(0, 0, 0), pack(65536, 0, 0), pack(0, 65536, 0), pack(0, 0, 65536),
			2, 2, 2);
		settings++;
		send(KIND_EVAL, 0, 0, 0, 0);
		send(KIND_EVAL, 0, 65536, 65536, 65536);
		send(KIND_EVAL, 0, 32768, 16384, 49152);
		send(KIND_EVAL, 0, -1, 0, 0);
		send(KIND_EVAL, 0, 0, 65537, 0);
		send(KIND_SET, 9'h1FF, coord_t'(524287), coord_t'(-524288), 0);
		send(KIND_SET, 0, coord_t'(524287), coord_t'(-524288), coord_t'(-524288));
		send(KIND_ADD, 0, 100, -100, -1);
		send(KIND_EVAL, 0, 0, 0, 0);
		send(KIND_ADD, 0, coord_t'(-524288), coord_t'(524287), coord_t'(524287));
		send(KIND_EVAL, 0, 1000, 2000, 3000);

		// negative handed box
		configure(pack(65536, 0, 0), pack(-65536, 0, 0), pack(0, 65536, 0),
			pack(0, 0, 65536), 3, 2, 2);
		settings++;
		send(KIND_EVAL, 0, 32768, 100, 65536);
		send(KIND_EVAL, 0, 65537, 0, 0);

		for (int ph = 0; ph < 14; ph++) begin
			o = pack(srand(131072), srand(131072), srand(131072));
			s = pack(major(), srand(8192), srand(8192));
			t = pack(srand(8192), major(), srand(8192));
			u = pack(srand(8192), srand(8192), major());
			case (ph % 7)
				0: begin ps = 2; pt = 2; pu = 2; end
				1: begin ps = 8; pt = 8; pu = 8; end
				2: begin ps = 0; pt = 15; pu = 1; end
				3: begin
					ps = $urandom_range(2, 8);
					pt = $urandom_range(2, 8);
					pu = $urandom_range(2, 8);
				end
				4: begin ps = 3; pt = 2; pu = 5; u = s; end
				5: begin
					o = 60'({$urandom(), $urandom()});
					s = 60'({$urandom(), $urandom()});
					t = 60'({$urandom(), $urandom()});
					u = 60'({$urandom(), $urandom()});
					ps = 2; pt = 3; pu = 2;
				end
				default: begin
					ps = $urandom_range(0, 15);
					pt = $urandom_range(0, 15);
					pu = $urandom_range(0, 15);
				end
			endcase
			configure(o, s, t, u, {28'($urandom()), 28'($urandom()), 4'(ps)},
				{28'($urandom()), 28'($urandom()), 4'(pt)},
				{28'($urandom()), 28'($urandom()), 4'(pu)});
			settings++;
			no_idle = (ph % 4 == 3);
			vol = clampn(ps) * clampn(pt) * clampn(pu);
			evals_left = vol > 64 ? 5 : 30;
			n_items = vol > 64 ? 12 : 40;
			for (int n = 0; n < n_items; n++) random_item(evals_left);
		end

		no_idle = 0;
		settle();
		$display("%0d items over %0d box settings; %0d points checked, %0d deformed",
			sent, settings, checked, deformed);
		if (fails == 0)
			$display("PASS bezier_volume_point_deform");
		else
			$display("FAIL bezier_volume_point_deform");
		$finish;
	end
endmodule

// File: files.f
rtl/bvpd_pkg.sv
rtl/bvpd_ifs.sv
rtl/bvpd_div.sv
rtl/bezier_volume_point_deform.sv
tb/sv/bvpd_checker.sv
tb/sv/bezier_volume_point_deform_tb.sv
